[hw/rtl/utf8_validating_decoder_macros.svh]
// assertion macros for the utf8 validating decoder
// expects clk and rst in the scope of the module that uses them
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

// property that must hold whenever the condition is met
`define UVD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the cycle after the condition
`define UVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/uvd_pkg.sv]
// shared types and constants of the utf8 validating decoder
// no dependencies
package uvd_pkg;

  localparam int CP_W  = 21;
  localparam int OFF_W = 32;

  // byte classes found by the front end
  localparam logic [2:0] CLS_ASCII = 3'd0;
  localparam logic [2:0] CLS_CONT  = 3'd1;
  localparam logic [2:0] CLS_LEAD2 = 3'd2;
  localparam logic [2:0] CLS_LEAD3 = 3'd3;
  localparam logic [2:0] CLS_LEAD4 = 3'd4;
  localparam logic [2:0] CLS_BAD   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;

  typedef logic [2:0] byte_class_t;

  typedef struct packed {
    logic [7:0]       text_byte;
    logic             end_of_text;
    byte_class_t      byte_class;
    logic [OFF_W-1:0] offset;
  } q_entry_t;

  // handshake between queue and back end
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

endpackage

[hw/rtl/uvd_byte_if.sv]
// byte input channel of the utf8 validating decoder
// no dependencies
interface uvd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[hw/rtl/uvd_result_if.sv]
// result channel of the utf8 validating decoder
// no dependencies
interface uvd_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic [2:0]  sequence_length;
  logic [31:0] sequence_offset;

  modport source (output valid, output code_point, output status, output sequence_length,
                  output sequence_offset, input ready);
  modport sink (input valid, input code_point, input status, input sequence_length,
                input sequence_offset, output ready);
endinterface

[hw/rtl/utf8_validating_decoder.sv]
// Streaming strict UTF-8 decoder with validation.
// Channel text (sink): one byte per transaction, text_byte and end_of_text
// marking the last byte of a text. Channel result (source): code_point, status
// (ok, invalid, truncated), sequence_length and sequence_offset of the lead byte.
// A byte that completes a sequence, is rejected, or ends a text mid-sequence gives one result; other
// bytes give none. The front end classifies bytes and counts the offset,
// a two-entry queue decouples it from the back end, which holds the sequence
// state and a result register.
// Throughput: one byte per cycle while the queue is not full; the back end
// consumes a queued byte every cycle the result register is free or being taken.
// A byte that causes a result passes through a queue entry and then the
// result register; bytes waiting ahead of it in the queue delay it further.
// Reset clears the offset, the queue, the sequence state and the result valid.
// When result.ready is low the result holds; the queue absorbs up to two bytes,
// then text.ready drops until the receiver takes the result.
// Offsets wrap modulo 2^min(OFFSET_BITS, 32) and restart at zero after end_of_text.
// depends on uvd_pkg, uvd_byte_if, uvd_result_if, uvd_front, uvd_queue, uvd_back
module utf8_validating_decoder import uvd_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  uvd_byte_if.sink     text,
  uvd_result_if.source result
);

  logic     push;
  logic     q_full;
  q_entry_t push_entry;
  q_entry_t head;
  q_ctrl_t  q_ctrl;
  q_ctrl_t  back_ctrl;

  uvd_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  uvd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head       (head),
    .ctrl_in    (back_ctrl),
    .ctrl_out   (q_ctrl)
  );

  uvd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_ctrl    (q_ctrl),
    .back_ctrl (back_ctrl),
    .result    (result)
  );

endmodule

[hw/rtl/uvd_front.sv]
// front end: accepts bytes, tracks the text offset and classifies each byte
// depends on uvd_pkg and uvd_byte_if
module uvd_front import uvd_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  uvd_byte_if.sink  text,
  input  logic      q_full,
  output logic      push,
  output q_entry_t  push_entry
);

  logic [OFFSET_BITS-1:0]       position;
  logic [OFFSET_BITS-1:0]       position_next;
  logic [OFFSET_BITS+OFF_W-1:0] position_ext;
  byte_class_t                  byte_class;

  assign text.ready = !q_full;
  assign push       = text.valid && !q_full;

  assign position_next = text.end_of_text ? '0 : position + 1'b1;
  assign position_ext  = {{OFF_W{1'b0}}, position};

  always_comb begin
    if (text.text_byte < 8'h80) begin
      byte_class = CLS_ASCII;
    end else if (text.text_byte < 8'hC0) begin
      byte_class = CLS_CONT;
    end else if (text.text_byte < 8'hC2) begin
      byte_class = CLS_BAD;
    end else if (text.text_byte < 8'hE0) begin
      byte_class = CLS_LEAD2;
    end else if (text.text_byte < 8'hF0) begin
      byte_class = CLS_LEAD3;
    end else if (text.text_byte < 8'hF5) begin
      byte_class = CLS_LEAD4;
    end else begin
      byte_class = CLS_BAD;
    end
  end

  always_comb begin
    push_entry.text_byte   = text.text_byte;
    push_entry.end_of_text = text.end_of_text;
    push_entry.byte_class  = byte_class;
    push_entry.offset      = position_ext[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      position <= position_next;
    end
  end

endmodule

[hw/rtl/uvd_queue.sv]
// two-entry queue between front end and back end
// depends on uvd_pkg
module uvd_queue import uvd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output q_entry_t head,
  input  q_ctrl_t  ctrl_in,
  output q_ctrl_t  ctrl_out
);

  q_entry_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full            = (count == 2'd2);
  assign head            = entries[rd_ptr];
  assign ctrl_out.valid  = (count != 2'd0);
  assign ctrl_out.pop    = ctrl_in.pop && ctrl_out.valid;

  always_comb begin
    count_next = count;
    if (push && !ctrl_out.pop) begin
      count_next = count + 2'd1;
    end else if (!push && ctrl_out.pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (ctrl_out.pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[hw/rtl/uvd_back.sv]
// back end: sequence state, validation, payload assembly and output register
// depends on uvd_pkg, uvd_result_if and the assertion macro header
`include "utf8_validating_decoder_macros.svh"

module uvd_back import uvd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  q_entry_t     head,
  input  q_ctrl_t      q_ctrl,
  output q_ctrl_t      back_ctrl,
  uvd_result_if.source result
);

  logic [1:0]       remaining;
  logic [1:0]       remaining_next;
  logic [2:0]       expected;
  logic [2:0]       expected_next;
  logic [7:0]       lead;
  logic [7:0]       lead_next;
  logic [CP_W-1:0]  acc;
  logic [CP_W-1:0]  acc_next;
  logic [OFF_W-1:0] start;
  logic [OFF_W-1:0] start_next;

  logic             out_valid;
  logic             out_valid_next;
  logic             take;
  logic             emit;
  logic [CP_W-1:0]  res_cp;
  logic [1:0]       res_status;
  logic [2:0]       res_len;
  logic [OFF_W-1:0] res_off;
  logic             first_cont;
  logic             second_ok;
  logic             bad;
  logic [7:0]       b;

  assign b             = head.text_byte;
  assign back_ctrl.pop = !out_valid || result.ready;
  assign back_ctrl.valid = out_valid;
  assign take          = q_ctrl.pop;

  always_comb begin
    case (lead)
      8'hE0:   second_ok = (b >= 8'hA0);
      8'hED:   second_ok = (b < 8'hA0);
      8'hF0:   second_ok = (b >= 8'h90);
      8'hF4:   second_ok = (b < 8'h90);
      default: second_ok = 1'b1;
    endcase
  end

  assign first_cont = (({1'b0, remaining} + 3'd1) == expected);
  assign bad        = (head.byte_class != CLS_CONT) || (first_cont && !second_ok);

  always_comb begin
    remaining_next = remaining;
    expected_next  = expected;
    lead_next      = lead;
    acc_next       = acc;
    start_next     = start;
    emit           = 1'b0;
    res_cp         = '0;
    res_status     = ST_OK;
    res_len        = 3'd0;
    res_off        = head.offset;
    if (take) begin
      if (remaining == 2'd0) begin
        unique case (head.byte_class)
          CLS_ASCII: begin
            emit   = 1'b1;
            res_cp = {{(CP_W-8){1'b0}}, b};
            res_len = 3'd1;
          end
          CLS_LEAD2: begin
            lead_next      = b;
            start_next     = head.offset;
            expected_next  = 3'd2;
            remaining_next = 2'd1;
            acc_next       = {{(CP_W-5){1'b0}}, b[4:0]};
          end
          CLS_LEAD3: begin
            lead_next      = b;
            start_next     = head.offset;
            expected_next  = 3'd3;
            remaining_next = 2'd2;
            acc_next       = {{(CP_W-4){1'b0}}, b[3:0]};
          end
          CLS_LEAD4: begin
            lead_next      = b;
            start_next     = head.offset;
            expected_next  = 3'd4;
            remaining_next = 2'd3;
            acc_next       = {{(CP_W-3){1'b0}}, b[2:0]};
          end
          default: begin
            emit       = 1'b1;
            res_status = ST_INVALID;
          end
        endcase
        if (head.end_of_text && remaining_next != 2'd0) begin
          remaining_next = 2'd0;
          emit           = 1'b1;
          res_status     = ST_TRUNC;
        end
      end else begin
        res_off = start;
        if (bad) begin
          remaining_next = 2'd0;
          emit           = 1'b1;
          res_status     = ST_INVALID;
        end else begin
          acc_next       = {acc[CP_W-7:0], b[5:0]};
          remaining_next = remaining - 2'd1;
          if (remaining == 2'd1) begin
            emit = 1'b1;
            if (acc_next > CP_MAX || (acc_next >= SURR_LO && acc_next <= SURR_HI)) begin
              res_status = ST_INVALID;
            end else begin
              res_cp  = acc_next;
              res_len = expected;
            end
          end else if (head.end_of_text) begin
            remaining_next = 2'd0;
            emit           = 1'b1;
            res_status     = ST_TRUNC;
          end
        end
      end
    end
  end

  assign out_valid_next = take ? emit : (out_valid && !result.ready);
  assign result.valid   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      remaining <= remaining_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    expected <= expected_next;
    lead     <= lead_next;
    acc      <= acc_next;
    start    <= start_next;
    if (take && emit) begin
      result.code_point      <= res_cp;
      result.status          <= res_status;
      result.sequence_length <= res_len;
      result.sequence_offset <= res_off;
    end
  end

  `UVD_ASSERT_IMP(a_ok_len, out_valid && result.status == ST_OK, result.sequence_length != 3'd0 && result.sequence_length <= 3'd4, "ok result with bad length")
  `UVD_ASSERT_IMP(a_err_zero, out_valid && result.status != ST_OK, result.code_point == '0 && result.sequence_length == 3'd0, "error result with payload")
  `UVD_ASSERT_IMP(a_rem_bound, remaining != 2'd0, {1'b0, remaining} < expected, "remaining count exceeds sequence length")
  `UVD_ASSERT_NEXT(a_stall_hold, out_valid && !result.ready, out_valid, "pending result dropped")

endmodule
